FILE: rtl/core/lbcc_pkg.sv
// ----------------------------------------------------------------------------
// Line box collision check package
// Shared constants, command codes and control bundles for the collision check.
// ----------------------------------------------------------------------------
`default_nettype none

package lbcc_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_OBSTACLES_DEF = 64;
	localparam int COORD_BITS_DEF    = 12;

	// Fixed field widths.
	localparam int SLOT_BITS  = 6;
	localparam int COUNT_BITS = 7;

	// Item commands.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Control for one box cell of the ring.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Control for the line evaluator.
	typedef struct packed {
		logic clear;
		logic valid;
	} eval_ctl_t;

endpackage : lbcc_pkg

`default_nettype wire

FILE: rtl/core/lbcc_if.sv
// ----------------------------------------------------------------------------
// Line box collision check channels
// Valid/ready channel for incoming items and for collision results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbcc_in_if #(
	parameter int COORD_BITS = lbcc_pkg::COORD_BITS_DEF
);
	import lbcc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [SLOT_BITS-1:0]  slot;
	logic [COORD_BITS-1:0] box_zmin;
	logic [COORD_BITS-1:0] box_xmin;
	logic [COORD_BITS-1:0] box_zmax;
	logic [COORD_BITS-1:0] box_xmax;
	logic [COORD_BITS-1:0] first_z;
	logic [COORD_BITS-1:0] first_x;
	logic [COORD_BITS-1:0] second_z;
	logic [COORD_BITS-1:0] second_x;

	modport source (
		output valid, cmd, slot, box_zmin, box_xmin, box_zmax, box_xmax,
		       first_z, first_x, second_z, second_x,
		input  ready
	);

	modport sink (
		input  valid, cmd, slot, box_zmin, box_xmin, box_zmax, box_xmax,
		       first_z, first_x, second_z, second_x,
		output ready
	);
endinterface : lbcc_in_if

interface lbcc_out_if;
	logic valid;
	logic ready;
	logic collision;

	modport source (output valid, collision, input ready);
	modport sink (input valid, collision, output ready);
endinterface : lbcc_out_if

`default_nettype wire

FILE: rtl/core/lbcc_cell.sv
// ----------------------------------------------------------------------------
// Box cell
// Holds one obstacle box; loads it from an item or takes its neighbor's box.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcc_cell #(
	parameter int COORD_BITS = lbcc_pkg::COORD_BITS_DEF
) (
	input  wire                      clk,
	input  lbcc_pkg::cell_ctl_t      ctl,
	input  wire  [4*COORD_BITS-1:0]  load_box,
	input  wire  [4*COORD_BITS-1:0]  next_box,
	output logic [4*COORD_BITS-1:0]  box
);
	import lbcc_pkg::*;

	logic [4*COORD_BITS-1:0] box_q;

	// Loads only happen while the ring is at rest, so the two never meet; the
	// box simply holds when neither is asked for.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			box_q <= load_box;
		end else if (ctl.shift) begin
			box_q <= next_box;
		end
	end

	assign box = box_q;

endmodule : lbcc_cell

`default_nettype wire

FILE: rtl/core/lbcc_eval.sv
// ----------------------------------------------------------------------------
// Line evaluator
// Two-stage check of one box against a line; accumulates a hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcc_eval #(
	parameter int COORD_BITS = lbcc_pkg::COORD_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  lbcc_pkg::eval_ctl_t           ctl,
	input  wire  signed [COORD_BITS:0]    a,
	input  wire  signed [COORD_BITS:0]    b,
	input  wire  signed [2*COORD_BITS:0]  c,
	input  wire         [4*COORD_BITS-1:0] box,
	output logic                          hit
);
	import lbcc_pkg::*;

	localparam int P_W = 2*COORD_BITS + 2;
	localparam int V_W = 2*COORD_BITS + 3;

	// Box layout is {zmin, xmin, zmax, xmax}, zmin in the top bits.
	logic [COORD_BITS-1:0] zmin, xmin, zmax, xmax;

	logic signed [P_W-1:0] pz_min_s1, pz_max_s1, px_min_s1, px_max_s1;
	logic                  valid_s1;
	logic signed [V_W-1:0] v [4];
	logic [3:0]            neg, pos;
	logic                  straddle;
	logic                  hit_q;

	assign zmin = box[4*COORD_BITS-1:3*COORD_BITS];
	assign xmin = box[3*COORD_BITS-1:2*COORD_BITS];
	assign zmax = box[2*COORD_BITS-1:COORD_BITS];
	assign xmax = box[COORD_BITS-1:0];

	// Stage 1: the four products that the corner values share.
	always_ff @(posedge clk) begin
		pz_min_s1 <= a * $signed({1'b0, zmin});
		pz_max_s1 <= a * $signed({1'b0, zmax});
		px_min_s1 <= b * $signed({1'b0, xmin});
		px_max_s1 <= b * $signed({1'b0, xmax});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	// Stage 2: corner values and their signs.
	always_comb begin
		v[0] = V_W'(pz_min_s1) - V_W'(px_min_s1) + V_W'(c);
		v[1] = V_W'(pz_min_s1) - V_W'(px_max_s1) + V_W'(c);
		v[2] = V_W'(pz_max_s1) - V_W'(px_max_s1) + V_W'(c);
		v[3] = V_W'(pz_max_s1) - V_W'(px_min_s1) + V_W'(c);
		for (int k = 0; k < 4; k++) begin
			neg[k] = v[k][V_W-1];
			pos[k] = !v[k][V_W-1] && (v[k] != '0);
		end
		straddle = (|neg) && (|pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (valid_s1 && straddle) begin
			hit_q <= 1'b1;
		end
	end

	assign hit = hit_q;

endmodule : lbcc_eval

`default_nettype wire

FILE: rtl/core/line_box_collision_check.sv
// ----------------------------------------------------------------------------
// Line box collision check
// Obstacle box table held in a ring of cells, swept past a line evaluator.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake     Payload
// item      in         valid/ready   cmd, slot, box bounds, two query nodes
// result    out        valid/ready   collision
// cfg       in         cfg_we only   cfg_wdata = obstacle_count
//
// A load item writes its box straight into the cell that its slot names;
// a slot at or beyond MAX_OBSTACLES writes nothing.
// A query item keeps the input closed until its result is handed on: the
// sequencer forms the line coefficients, rotates the ring of box cells one
// place per cycle past the evaluator for a full turn, drains the evaluator
// pipeline and hands the result to the output register. The ring size sets
// the length of a query; the obstacle count does not.
// The result register parts the two sides, so the next item is taken while a
// result still waits; a query whose result finds that register full waits in
// its last step. Reset clears control state and obstacle_count; box contents
// stay undefined until loaded.
//
`default_nettype none

module line_box_collision_check #(
	parameter int MAX_OBSTACLES = lbcc_pkg::MAX_OBSTACLES_DEF,
	parameter int COORD_BITS    = lbcc_pkg::COORD_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	lbcc_in_if.sink                             item,
	lbcc_out_if.source                          result,
	input  wire                                 cfg_we,
	input  wire  [lbcc_pkg::COUNT_BITS-1:0]     cfg_wdata
);
	import lbcc_pkg::*;

	localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int BOX_W = 4 * COORD_BITS;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COEF  = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]            state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [COUNT_BITS-1:0] count_q;

	// Line coefficients: A = x2-x1, B = z2-z1, C = z2*x1 - z1*x2.
	logic signed [COORD_BITS:0]   a_q, b_q;
	logic        [2*COORD_BITS-1:0] prod1_q, prod2_q;
	logic signed [2*COORD_BITS:0] c_q;

	logic out_valid_q;
	logic collision_q;

	logic item_acc;
	logic load_acc;
	logic query_acc;
	logic out_load;
	logic hit;

	eval_ctl_t        eval_ctl;
	logic [BOX_W-1:0] load_box;
	logic [BOX_W-1:0] box_w [MAX_OBSTACLES];

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign load_acc   = item_acc && (item.cmd == CMD_LOAD);
	assign query_acc  = item_acc && (item.cmd == CMD_QUERY);
	assign load_box   = {item.box_zmin, item.box_xmin, item.box_zmax, item.box_xmax};

	// The result register takes the hit flag once it is empty or being drained.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// Sequencer: coefficient step, ring sweep, pipeline drain, hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					idx_q   <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (idx_q == IDX_W'(MAX_OBSTACLES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Coefficients. The two cross products are registered before C is formed.
	always_ff @(posedge clk) begin
		if (query_acc) begin
			a_q     <= {1'b0, item.second_x} - {1'b0, item.first_x};
			b_q     <= {1'b0, item.second_z} - {1'b0, item.first_z};
			prod1_q <= item.second_z * item.first_x;
			prod2_q <= item.first_z * item.second_x;
		end
		if (state_q == ST_COEF) begin
			c_q <= $signed({1'b0, prod1_q}) - $signed({1'b0, prod2_q});
		end
	end

	// Ring of box cells. During a sweep every cell takes its upper neighbor's
	// box, so cell 0 shows entry idx_q; after a full turn every box is home.
	for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_OBSTACLES;

		cell_ctl_t cell_ctl;

		assign cell_ctl.load  = load_acc && (32'(item.slot) == 32'(i));
		assign cell_ctl.shift = (state_q == ST_SWEEP);

		lbcc_cell #(
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.load_box (load_box),
			.next_box (box_w[NXT]),
			.box      (box_w[i])
		);
	end

	// Entries at or past obstacle_count are swept but not scored, which also
	// caps a count above the table size.
	assign eval_ctl.clear = query_acc;
	assign eval_ctl.valid = (state_q == ST_SWEEP) && (32'(idx_q) < 32'(count_q));

	lbcc_eval #(
		.COORD_BITS (COORD_BITS)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eval_ctl),
		.a      (a_q),
		.b      (b_q),
		.c      (c_q),
		.box    (box_w[0]),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			collision_q <= hit;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.collision = collision_q;

endmodule : line_box_collision_check

`default_nettype wire

FILE: rtl/core/lbcc_checker.sv
// ----------------------------------------------------------------------------
// Line box collision check port checker
// Port-level assertions on items, results and queries in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcc_checker (
	input wire clk,
	input wire arst_n,
	input wire item_valid,
	input wire item_ready,
	input wire item_cmd,
	input wire result_valid,
	input wire result_ready,
	input wire collision
);
	import lbcc_pkg::*;

	logic       query_acc;
	logic       result_acc;
	logic [1:0] pend_q;

	assign query_acc  = item_valid && item_ready && (item_cmd == CMD_QUERY);
	assign result_acc = result_valid && result_ready;

	// Queries accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (query_acc && !result_acc && (pend_q != 2'd3)) begin
			pend_q <= pend_q + 1'b1;
		end else if (!query_acc && result_acc && (pend_q != 2'd0)) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(collision))
		else $error("result dropped or changed while stalled");

	a_result_has_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result without an outstanding query");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two queries outstanding");

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !item_ready)
		else $error("item taken during a query sweep");

endmodule : lbcc_checker

bind line_box_collision_check lbcc_checker u_lbcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_cmd     (item.cmd),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.collision    (result.collision)
);

`default_nettype wire
